[src/rfps_pkg.sv]
// Shared types and constants for the RGB fade PWM sequencer.
package rfps_pkg;

  localparam int PWM_BITS = 8;

  localparam logic [PWM_BITS-1:0] RAMP_TOP    = 8'd255;
  localparam logic [PWM_BITS-1:0] WHITE_LIMIT = 8'd85;
  localparam logic [PWM_BITS-1:0] PAIR_LIMIT  = 8'd127;
  localparam logic [15:0]         TPS_RESET   = 16'd375;

  typedef logic [PWM_BITS-1:0] level_t;

  typedef enum logic [2:0] {
    MODE_RED   = 3'd0,
    MODE_GREEN = 3'd1,
    MODE_BLUE  = 3'd2,
    MODE_WHITE = 3'd3,
    MODE_RG    = 3'd4,
    MODE_GB    = 3'd5,
    MODE_RB    = 3'd6
  } mode_t;

  typedef struct packed {
    level_t r;
    level_t g;
    level_t b;
  } levels_t;

  typedef struct packed {
    mode_t  mode;
    level_t index;
    logic   rising;
  } seq_status_t;

endpackage

[src/rgb_fade_pwm_sequencer.sv]
// Top level of the RGB fade PWM sequencer: channels and result register.
// Usage:
//   Each input word carries one bit, tick. A word with tick = 1 advances the
//   8-bit PWM counter by one and counts toward the next fade step; tick = 0
//   changes nothing but still yields a result word.
//   Every accepted input word gives exactly one result word holding the three
//   pin levels, the sequencer mode, the ramp index and the ramp direction as
//   they stand after that tick.
//   cfg_we / cfg_wdata set ticks_per_step (reset 375; 0 acts as 1). Write it
//   only while no result is outstanding.
// Timing:
//   The result is in the output register in the cycle after acceptance.
//   One word per cycle is sustained while out_tready is high: divider, ramp
//   step and level select are combinational: state update and capture share an edge.
//   When the receiver stalls, the result register holds its word and
//   in_tready drops until it is taken; the word is taken and a new one
//   accepted in the same cycle when out_tready is high.
// Reset:
//   rst_n (synchronous) clears the PWM, sequencer and pins, sets rising,
//   restores ticks_per_step to 375 and empties the result register.
module rgb_fade_pwm_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [0] tick, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [0] red_out, [1] green_out, [2] blue_out,
                                   // [5:3] mode_now, [13:6] ramp_position,
                                   // [14] ramp_rising, [15] zero
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import rfps_pkg::*;

  logic        in_fire;
  logic        advance;
  levels_t     live;
  logic [2:0]  pins_nxt;
  seq_status_t status_nxt;
  logic        out_valid_r;
  logic [15:0] out_data_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign advance   = in_fire && in_tdata[0];

  rfps_fade u_fade (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .live       (live),
    .status_nxt (status_nxt)
  );

  rfps_pwm u_pwm (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .live     (live),
    .pins_nxt (pins_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {1'b0, status_nxt.rising, status_nxt.index,
                     status_nxt.mode, pins_nxt[2], pins_nxt[1], pins_nxt[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[src/rfps_pwm.sv]
// 8-bit PWM counter with level latch at wrap and per-channel pin compare.
module rfps_pwm (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  rfps_pkg::levels_t live,
  output logic [2:0]       pins_nxt
);
  import rfps_pkg::*;

  level_t     count_r, count_nxt;
  levels_t    latched_r, latched_nxt;
  logic [2:0] pins_r;
  logic       wrap;
  logic [2:0] lit;

  always_comb begin
    count_nxt   = count_r;
    latched_nxt = latched_r;
    pins_nxt    = pins_r;
    wrap        = 1'b0;
    lit         = pins_r;
    if (advance) begin
      count_nxt = count_r + level_t'(1);
      wrap      = (count_nxt == '0);
      if (wrap) begin
        latched_nxt = live;
        lit         = 3'b111;
      end
      // compare against the freshly latched levels, so level 0 stays dark
      pins_nxt[0] = lit[0] & (count_nxt != latched_nxt.r);
      pins_nxt[1] = lit[1] & (count_nxt != latched_nxt.g);
      pins_nxt[2] = lit[2] & (count_nxt != latched_nxt.b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      latched_r <= '0;
      pins_r    <= '0;
    end else begin
      count_r   <= count_nxt;
      latched_r <= latched_nxt;
      pins_r    <= pins_nxt;
    end
  end

endmodule

[src/rfps_fade.sv]
// Fade sequencer: step divider, ramp index, mode walk and live levels.
module rfps_fade (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_wdata,
  output rfps_pkg::levels_t     live,
  output rfps_pkg::seq_status_t status_nxt
);
  import rfps_pkg::*;

  logic [15:0] tps_r;
  logic [15:0] dwell_r, dwell_nxt, dwell_inc;
  mode_t       mode_r, mode_nxt;
  level_t      idx_r, idx_nxt;
  logic        dir_r, dir_nxt;
  levels_t     live_r, live_nxt;
  logic        step;

  always_comb begin
    dwell_inc = dwell_r + 16'd1;
    step      = (dwell_inc >= tps_r) || (dwell_inc == 16'd0);
    dwell_nxt = dwell_r;
    mode_nxt  = mode_r;
    idx_nxt   = idx_r;
    dir_nxt   = dir_r;
    live_nxt  = live_r;
    if (advance) begin
      dwell_nxt = step ? 16'd0 : dwell_inc;
      if (step) begin
        if (dir_r) begin
          // top of ramp only turns around, index holds at the top
          if (idx_r == RAMP_TOP) dir_nxt = 1'b0;
          else                   idx_nxt = idx_r + level_t'(1);
        end else begin
          if (idx_r == '0) begin
            mode_nxt = (mode_r == MODE_RB) ? MODE_RED : mode_t'(mode_r + 3'd1);
            dir_nxt  = 1'b1;
          end else begin
            idx_nxt = idx_r - level_t'(1);
          end
        end
        case (mode_nxt)
          MODE_RED:   live_nxt = '{r: idx_nxt, g: '0, b: '0};
          MODE_GREEN: live_nxt = '{r: '0, g: idx_nxt, b: '0};
          MODE_BLUE:  live_nxt = '{r: '0, g: '0, b: idx_nxt};
          MODE_WHITE: if (idx_nxt <= WHITE_LIMIT) live_nxt = '{r: idx_nxt, g: idx_nxt, b: idx_nxt};
          MODE_RG:    if (idx_nxt <= PAIR_LIMIT)  live_nxt = '{r: idx_nxt, g: idx_nxt, b: '0};
          MODE_GB:    if (idx_nxt <= PAIR_LIMIT)  live_nxt = '{r: '0, g: idx_nxt, b: idx_nxt};
          MODE_RB:    if (idx_nxt <= PAIR_LIMIT)  live_nxt = '{r: idx_nxt, g: '0, b: idx_nxt};
          default:    live_nxt = live_r;
        endcase
      end
    end
  end

  assign live       = live_r;
  assign status_nxt = '{mode: mode_nxt, index: idx_nxt, rising: dir_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r   <= TPS_RESET;
      dwell_r <= '0;
      mode_r  <= MODE_RED;
      idx_r   <= '0;
      dir_r   <= 1'b1;
      live_r  <= '0;
    end else begin
      if (cfg_we) tps_r <= cfg_wdata;
      dwell_r <= dwell_nxt;
      mode_r  <= mode_nxt;
      idx_r   <= idx_nxt;
      dir_r   <= dir_nxt;
      live_r  <= live_nxt;
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking stream testbench for the RGB fade PWM sequencer.
module tb_top;
  import rfps_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [0] tick, [7:1] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;   // [0] red, [1] green, [2] blue, [5:3] mode,
                            // [13:6] ramp position, [14] rising, [15] zero
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  rgb_fade_pwm_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // fader model state
  logic [15:0] step_period;
  logic [15:0] dwell;
  level_t      pwm_cnt;
  level_t      latched [3];
  level_t      live [3];
  logic [2:0]  pins;        // bit 0 red
  logic [2:0]  mode;
  level_t      ramp;
  logic        rising;

  bit          tick_q [$];
  logic [14:0] pin_status_q [$];  // {rising, ramp, mode, pins}
  logic [14:0] want;
  int          send_gap;
  int          recv_gap;
  bit          calm;
  int          mismatches;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int next_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(8, 40);
  endfunction

  function void set_live(level_t r, level_t g, level_t b);
    live[0] = r;
    live[1] = g;
    live[2] = b;
  endfunction

  function void fade_step();
    if (rising) begin
      if (ramp == RAMP_TOP) rising = 1'b0;
      else ramp = ramp + 8'd1;
    end else if (ramp == 8'd0) begin
      mode   = (mode >= MODE_RB) ? MODE_RED : mode + 3'd1;
      rising = 1'b1;
    end else begin
      ramp = ramp - 8'd1;
    end
    case (mode)
      MODE_RED:   set_live(ramp, 8'd0, 8'd0);
      MODE_GREEN: set_live(8'd0, ramp, 8'd0);
      MODE_BLUE:  set_live(8'd0, 8'd0, ramp);
      MODE_WHITE: if (ramp <= WHITE_LIMIT) set_live(ramp, ramp, ramp);
      MODE_RG:    if (ramp <= PAIR_LIMIT) set_live(ramp, ramp, 8'd0);
      MODE_GB:    if (ramp <= PAIR_LIMIT) set_live(8'd0, ramp, ramp);
      MODE_RB:    if (ramp <= PAIR_LIMIT) set_live(ramp, 8'd0, ramp);
      default: ;
    endcase
  endfunction

  function void advance_fader(logic tick);
    if (tick) begin
      // PWM uses the levels from before this tick's fade step
      pwm_cnt = pwm_cnt + 8'd1;
      if (pwm_cnt == 8'd0) begin
        for (int c = 0; c < 3; c++) latched[c] = live[c];
        pins = 3'b111;
      end
      for (int c = 0; c < 3; c++)
        if (pwm_cnt == latched[c]) pins[c] = 1'b0;
      dwell = dwell + 16'd1;
      // zero period acts as one
      if (dwell >= step_period || dwell == 16'd0) begin
        dwell = 16'd0;
        fade_step();
      end
    end
    pin_status_q.push_back({rising, ramp, mode, pins});
  endfunction

  // driver: feeds tick words, tracks the model on each accepted word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid   <= 1'b0;
      send_gap    = 0;
      step_period = TPS_RESET;
      dwell       = 16'd0;
      pwm_cnt     = 8'd0;
      for (int c = 0; c < 3; c++) begin
        latched[c] = 8'd0;
        live[c]    = 8'd0;
      end
      pins   = 3'b000;
      mode   = MODE_RED;
      ramp   = 8'd0;
      rising = 1'b1;
    end else begin
      if (cfg_we) step_period = cfg_wdata;
      if (in_tvalid && in_tready) advance_fader(in_tdata[0]);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {7'd0, tick_q.pop_front()};
          send_gap  = next_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // monitor: random back-pressure, compares each taken word
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap   = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pin_status_q.size() == 0) begin
          $display("%0t unexpected word: expected none, actual %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = pin_status_q.pop_front();
          check_field("red_out", want[0], out_tdata[0]);
          check_field("green_out", want[1], out_tdata[1]);
          check_field("blue_out", want[2], out_tdata[2]);
          check_field("mode_now", want[5:3], out_tdata[5:3]);
          check_field("ramp_position", want[13:6], out_tdata[13:6]);
          check_field("ramp_rising", want[14], out_tdata[14]);
        end
        recv_gap = next_gap();
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (tick_q.size() != 0 || in_tvalid || pin_status_q.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_step(logic [15:0] period);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= period;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(logic [15:0] period, int count, int tick_pct);
    set_step(period);
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      tick_q.push_back($urandom_range(0, 99) < tick_pct);
    end
    wait_idle();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'd0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = 16'd0;
    calm       = 1'b0;
    mismatches = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset period, idle and live ticks
    tick_q = '{0, 1, 1, 1, 0, 1};
    wait_idle();
    // zero period: a step on every tick
    set_step(16'd0);
    tick_q = '{1, 1, 1, 0, 1, 1, 1, 1, 1, 1};
    wait_idle();
    set_step(16'hFFFF);
    tick_q = '{1, 0, 1};
    wait_idle();

    // fast runs carry the ramp through the first few modes
    run_phase(16'd0, 600, 97);
    run_phase(16'hFFFF, 40, 90);
    run_phase(16'd2, 60, 95);      // dwell already past the new period
    run_phase(16'd1, 600, 97);
    run_phase(TPS_RESET, 60, 95);
    run_phase(16'($urandom_range(4, 40)), 60, 80);
    run_phase(16'd0, 360, 98);

    repeat (4) @(posedge clk);
    if (mismatches == 0 && pin_status_q.size() == 0) begin
      $display("[rgb_fade_pwm_sequencer] OK");
    end else begin
      $display("[rgb_fade_pwm_sequencer] ERROR");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("[rgb_fade_pwm_sequencer] ERROR");
    $finish;
  end

endmodule

[rgb_fade_pwm_sequencer.f]
src/rfps_pkg.sv
src/rfps_pwm.sv
src/rfps_fade.sv
src/rgb_fade_pwm_sequencer.sv
tb/tb_top.sv
